### rtl/uvs_pkg.sv
`timescale 1ns / 1ps

package uvs_pkg;

    // Largest stack or sector count accepted
    localparam int MAX_DIV = 256;

    // Fixed-point constants, Q2.30 unless noted
    localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;

    // Taylor denominators of the sine and cosine chains, innermost first
    localparam logic [6:0] DIV_S [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] DIV_C [4] = '{7'd90, 7'd56, 7'd30, 7'd12};

    // Reciprocals floor(2^32 / d) for the constant divisions
    localparam logic [31:0] MAG_S [4] = '{
        32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
    localparam logic [31:0] MAG_C [4] = '{
        32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
        32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12)};

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_STACKS  = 2'd1,
        REG_SECTORS = 2'd2
    } uvs_reg_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [8:0]  stacks;
        logic [8:0]  sectors;
    } uvs_cfg_t;

    // Sideband that travels with every item
    typedef struct packed {
        logic        err;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
    } uvs_tag_t;

    // Divider result: stack phase and sector phase in turns * 2^32
    typedef struct packed {
        uvs_tag_t    tag;
        logic [31:0] ph_u;
        logic [31:0] ph_v;
    } uvs_ph_t;

    // One sine/cosine lane
    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] ds;
        logic [31:0] dc;
        logic [31:0] qs;
        logic [31:0] qc;
        logic [31:0] s;
        logic [31:0] c;
    } uvs_lane_t;

    // Lane 0 is the stack angle, lane 1 the sector angle
    typedef struct packed {
        uvs_tag_t             tag;
        uvs_lane_t [1:0]      lane;
    } uvs_sc_t;

    // Output stage record
    typedef struct packed {
        uvs_tag_t             tag;
        logic [2:0][31:0]     p;
        logic [2:0][63:0]     m;
        logic [2:0][15:0]     nrm;
        logic [2:0][16:0]     pos;
    } uvs_cb_t;

    // Q2.30 product, floored
    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

    // Quotient estimate by reciprocal, low by at most one
    function automatic logic [31:0] div_est(input logic [31:0] a, input logic [31:0] m);
        logic [63:0] p;
        p = 64'(a) * 64'(m);
        return p[63:32];
    endfunction

    // Correct the estimate with one compare
    function automatic logic [31:0] div_fix(input logic [31:0] a, input logic [31:0] q0,
                                            input logic [6:0] d);
        logic [31:0] r;
        r = a - 32'(q0 * 32'(d));
        return (r >= 32'(d)) ? q0 + 32'd1 : q0;
    endfunction

    // Divide by 2^k, rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned k);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (k - 1))) >> k;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

### rtl/uvs_divider.sv
`timescale 1ns / 1ps

module uvs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  uvs_pkg::uvs_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [8:0]        in_i,
    input  logic [8:0]        in_j,
    output logic              out_valid,
    input  logic              out_ready,
    output uvs_pkg::uvs_ph_t  out_data
);
    import uvs_pkg::*;

    // One quotient bit per stage
    localparam int NST = 32;
    // Lanes: stack phase, sector phase, tex_t, tex_s
    localparam int STEPS [4] = '{31, 32, 16, 16};

    typedef struct packed {
        logic             err;
        logic [3:0]       top;
        logic [3:0][8:0]  r;
        logic [3:0][31:0] q;
    } uvs_dv_t;

    uvs_dv_t          st_reg  [NST];
    uvs_dv_t          st_next [NST];
    logic [NST-1:0]   v_reg;
    logic [NST:0]     en;
    uvs_dv_t          init;

    // Range check and first remainder
    always_comb
    begin
        init     = '0;
        init.err = (cfg.stacks == 9'd0) || (cfg.stacks > 9'(MAX_DIV)) ||
                   (cfg.sectors == 9'd0) || (cfg.sectors > 9'(MAX_DIV)) ||
                   (in_i > cfg.stacks) || (in_j > cfg.sectors);
        init.top[0] = (in_i == cfg.stacks);
        init.top[1] = (in_j == cfg.sectors);
        init.top[2] = init.top[0];
        init.top[3] = init.top[1];
        init.r[0]   = init.top[0] ? 9'd0 : in_i;
        init.r[1]   = init.top[1] ? 9'd0 : in_j;
        init.r[2]   = init.r[0];
        init.r[3]   = init.r[1];
    end

    // Advance a stage when it is empty or the one after it advances
    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        uvs_dv_t base;

        if (k == 0)
        begin : g_first
            assign base = init;
        end
        else
        begin : g_rest
            assign base = st_reg[k - 1];
        end

        // One restoring step in each lane that is active here
        always_comb
        begin
            logic [8:0]  n;
            logic [31:0] hb;
            logic [9:0]  r2;
            st_next[k] = base;
            for (int l = 0; l < 4; l++)
            begin
                n  = (l % 2 == 0) ? cfg.stacks : cfg.sectors;
                hb = 32'(n >> 1) >> (31 - k);
                r2 = {base.r[l], hb[0]};
                if (k >= NST - STEPS[l])
                begin
                    if (r2 >= {1'b0, n})
                    begin
                        st_next[k].r[l] = 9'(r2 - {1'b0, n});
                        st_next[k].q[l] = {base.q[l][30:0], 1'b1};
                    end
                    else
                    begin
                        st_next[k].r[l] = r2[8:0];
                        st_next[k].q[l] = {base.q[l][30:0], 1'b0};
                    end
                end
            end
        end

        // Hold valid bits
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    // Assemble phases and texture coordinates
    always_comb
    begin
        out_data           = '0;
        out_data.tag.err   = st_reg[NST-1].err;
        out_data.tag.tex_t = {st_reg[NST-1].top[2], st_reg[NST-1].q[2][15:0]};
        out_data.tag.tex_s = {st_reg[NST-1].top[3], st_reg[NST-1].q[3][15:0]};
        out_data.ph_u      = {st_reg[NST-1].top[0], st_reg[NST-1].q[0][30:0]};
        out_data.ph_v      = st_reg[NST-1].q[1];
    end

    assign out_valid = v_reg[NST-1];

endmodule

### rtl/uvs_sincos.sv
`timescale 1ns / 1ps

module uvs_sincos (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  uvs_pkg::uvs_ph_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output uvs_pkg::uvs_sc_t out_data
);
    import uvs_pkg::*;

    localparam int NST = 16;

    uvs_sc_t        st_reg  [NST];
    uvs_sc_t        st_next [NST];
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;
    uvs_sc_t        init;

    function automatic uvs_lane_t lane_est(input uvs_lane_t d, input int n);
        uvs_lane_t o;
        o    = d;
        o.qs = div_est(d.ds, MAG_S[n]);
        o.qc = div_est(d.dc, MAG_C[n]);
        return o;
    endfunction

    function automatic uvs_lane_t lane_fix(input uvs_lane_t d, input int n);
        uvs_lane_t o;
        o   = d;
        o.s = ONE_Q30 - div_fix(d.ds, d.qs, DIV_S[n]);
        o.c = ONE_Q30 - div_fix(d.dc, d.qc, DIV_C[n]);
        return o;
    endfunction

    function automatic uvs_lane_t lane_mul(input uvs_lane_t d);
        uvs_lane_t o;
        o    = d;
        o.ds = qmul(d.x2, d.s);
        o.dc = qmul(d.x2, d.c);
        return o;
    endfunction

    // Work done by each stage on one lane
    function automatic uvs_lane_t lane_step(input int k, input uvs_lane_t d);
        uvs_lane_t   o;
        logic [31:0] r;
        logic [63:0] p;
        logic [31:0] sa;
        logic [31:0] ca;
        o  = d;
        r  = {2'b00, d.x[29:0]};
        p  = 64'(d.x) * 64'(PI_Q30);
        sa = d.swap ? d.c : d.s;
        ca = d.swap ? d.s : d.c;
        case (k)
            0:
            begin
                o.quad = d.x[31:30];
                o.swap = r > HALF_Q30;
                o.x    = o.swap ? ONE_Q30 - r : r;
            end
            1:  o.x = p[62:31];
            2:
            begin
                o.x2 = qmul(d.x, d.x);
                o.ds = o.x2;
                o.dc = o.x2;
            end
            3:  o = lane_est(d, 0);
            4:  o = lane_fix(d, 0);
            5:  o = lane_mul(d);
            6:  o = lane_est(d, 1);
            7:  o = lane_fix(d, 1);
            8:  o = lane_mul(d);
            9:  o = lane_est(d, 2);
            10: o = lane_fix(d, 2);
            11: o = lane_mul(d);
            12: o = lane_est(d, 3);
            13: o = lane_fix(d, 3);
            14:
            begin
                o.s = qmul(d.x, d.s);
                o.c = ONE_Q30 - (qmul(d.x2, d.c) >> 1);
            end
            15:
            begin
                // Apply the quadrant: signs and order
                case (d.quad)
                    2'd0:
                    begin
                        o.s = sa;
                        o.c = ca;
                    end
                    2'd1:
                    begin
                        o.s = ca;
                        o.c = -sa;
                    end
                    2'd2:
                    begin
                        o.s = -sa;
                        o.c = -ca;
                    end
                    default:
                    begin
                        o.s = -ca;
                        o.c = sa;
                    end
                endcase
            end
            default: o = d;
        endcase
        return o;
    endfunction

    // Load phases into the angle fields
    always_comb
    begin
        init           = '0;
        init.tag       = in_data.tag;
        init.lane[0].x = in_data.ph_u;
        init.lane[1].x = in_data.ph_v;
    end

    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        uvs_sc_t base;

        if (k == 0)
        begin : g_first
            assign base = init;
        end
        else
        begin : g_rest
            assign base = st_reg[k - 1];
        end

        always_comb
        begin
            st_next[k].tag = base.tag;
            for (int l = 0; l < 2; l++)
            begin
                st_next[k].lane[l] = lane_step(k, base.lane[l]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

### rtl/uvs_output.sv
`timescale 1ns / 1ps

module uvs_output (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [15:0]      radius,
    input  logic             in_valid,
    output logic             in_ready,
    input  uvs_pkg::uvs_sc_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output uvs_pkg::uvs_cb_t out_data
);
    import uvs_pkg::*;

    localparam int NST = 4;

    uvs_cb_t        st_reg  [NST];
    uvs_cb_t        st_next [NST];
    logic [NST-1:0] v_reg;
    logic [NST:0]   en;
    uvs_cb_t        init;

    function automatic uvs_cb_t cb_step(input int k, input uvs_cb_t d, input logic [15:0] rad);
        uvs_cb_t          o;
        logic signed [63:0] t;
        logic signed [63:0] pr;
        o = d;
        case (k)
            1:
            begin
                for (int n = 0; n < 2; n++)
                begin
                    t      = rnd_shift($signed(d.m[n]), 30);
                    o.p[n] = t[31:0];
                end
            end
            2:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    pr       = $signed({1'b0, rad}) * $signed(d.p[n]);
                    o.m[n]   = pr;
                    t        = rnd_shift($signed(d.p[n]), 16);
                    o.nrm[n] = t[15:0];
                end
            end
            3:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    t        = rnd_shift($signed(d.m[n]), 30);
                    o.pos[n] = t[16:0];
                end
                // Zero the position, normal and texture fields of a rejected item
                if (d.tag.err)
                begin
                    o.pos       = '0;
                    o.nrm       = '0;
                    o.tag.tex_s = '0;
                    o.tag.tex_t = '0;
                end
            end
            default: o = d;
        endcase
        return o;
    endfunction

    // First stage: sin u * cos v and sin u * sin v
    always_comb
    begin
        logic signed [63:0] mx;
        logic signed [63:0] my;
        mx        = $signed(in_data.lane[0].s) * $signed(in_data.lane[1].c);
        my        = $signed(in_data.lane[0].s) * $signed(in_data.lane[1].s);
        init      = '0;
        init.tag  = in_data.tag;
        init.m[0] = mx;
        init.m[1] = my;
        init.p[2] = in_data.lane[0].c;
    end

    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign in_ready = en[0];

    for (genvar k = 0; k < NST; k++)
    begin : g_st
        if (k == 0)
        begin : g_first
            assign st_next[k] = init;
        end
        else
        begin : g_rest
            assign st_next[k] = cb_step(k, st_reg[k - 1], radius);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

### rtl/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// Pipeline from input beat to result beat: 32 divider stages, 16 sine/cosine
// stages, 4 product and rounding stages.
// Throughput: one vertex per cycle; the pipeline stalls stage by stage and
// empty stages fill while the output waits.
// Reset: rst_n clears all valid bits; radius 1.0, 16 stacks, 32 sectors.

module uv_sphere_vertex_generator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // stack_index[8:0], sector_index[17:9], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // pos_x, pos_y, pos_z (17 each), norm_x, norm_y,
                                    // norm_z (16 each), tex_s, tex_t (17 each), zero pad
    output logic [0:0]   m_tuser,   // index_error
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import uvs_pkg::*;

    logic [15:0] radius_reg;
    logic [8:0]  stacks_reg;
    logic [8:0]  sectors_reg;
    uvs_cfg_t    cfg;

    logic    dv_valid;
    logic    dv_ready;
    uvs_ph_t dv_data;
    logic    sc_valid;
    logic    sc_ready;
    uvs_sc_t sc_data;
    uvs_cb_t res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd256;
            stacks_reg  <= 9'd16;
            sectors_reg <= 9'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_STACKS:  stacks_reg  <= cfg_data[8:0];
                REG_SECTORS: sectors_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign cfg.radius  = radius_reg;
    assign cfg.stacks  = stacks_reg;
    assign cfg.sectors = sectors_reg;

    uvs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_i      (s_tdata[8:0]),
        .in_j      (s_tdata[17:9]),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    uvs_sincos u_sc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_data   (dv_data),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_data  (sc_data)
    );

    uvs_output u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (radius_reg),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_data   (sc_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result beat
    assign m_tdata = {3'b000, res.tag.tex_t, res.tag.tex_s,
                      res.nrm[2], res.nrm[1], res.nrm[0],
                      res.pos[2], res.pos[1], res.pos[0]};
    assign m_tuser = res.tag.err;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("rejected vertex carries data");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |->
            m_tdata[115:99] <= 17'd65536 && m_tdata[132:116] <= 17'd65536)
        else $error("texture coordinate above one");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            $signed(m_tdata[98:83]) >= -16'sd16384 && $signed(m_tdata[98:83]) <= 16'sd16384)
        else $error("normal z out of range");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

### test/uv_sphere_vertex_generator_test.sv
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_test;
    import uvs_pkg::*;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned Q30_PI  = 64'd3373259426;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic        index_error;
    } vertex_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    // Shadow of the block's configuration
    logic [15:0] radius_q88;
    logic [8:0]  stack_count;
    logic [8:0]  sector_count;

    vertex_t pending_vertices[$];
    int      fail_count;
    int      hold_ask;

    uv_sphere_vertex_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Divide by 2^k, rounding half away from zero
    function automatic longint shift_round_away(input longint v, input int k);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        m = (m + (64'd1 << (k - 1))) >> k;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Sine and cosine of a Q2.30 angle in [0, pi/4] by Taylor chains
    function automatic void taylor_sincos(input longint unsigned x,
                                          output longint unsigned sn,
                                          output longint unsigned cs);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 72;
        t = Q30_ONE - ((x2 * t) >> 30) / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        sn = (x * t) >> 30;
        t = Q30_ONE - x2 / 90;
        t = Q30_ONE - ((x2 * t) >> 30) / 56;
        t = Q30_ONE - ((x2 * t) >> 30) / 30;
        t = Q30_ONE - ((x2 * t) >> 30) / 12;
        t = Q30_ONE - ((x2 * t) >> 30) / 2;
        cs = t;
    endfunction

    // Signed sine and cosine of a phase in turns * 2^32
    function automatic void phase_trig(input logic [31:0] ph, output longint sn,
                                       output longint cs);
        longint unsigned r;
        longint unsigned a;
        longint unsigned b;
        longint sa;
        longint ca;
        logic mirror;
        r = ph[29:0];
        mirror = r > (Q30_ONE >> 1);
        if (mirror)
            r = Q30_ONE - r;
        taylor_sincos((r * Q30_PI) >> 31, a, b);
        sa = mirror ? longint'(b) : longint'(a);
        ca = mirror ? longint'(a) : longint'(b);
        case (ph[31:30])
            2'd0:    begin sn = sa;  cs = ca;  end
            2'd1:    begin sn = ca;  cs = -sa; end
            2'd2:    begin sn = -sa; cs = -ca; end
            default: begin sn = -ca; cs = sa;  end
        endcase
    endfunction

    function automatic vertex_t predict_vertex(input logic [8:0] i, input logic [8:0] j);
        vertex_t v;
        longint unsigned ns;
        longint unsigned nv;
        longint unsigned ph;
        longint sw;
        longint cw;
        longint sv;
        longint cv;
        longint p [3];
        longint rad;
        logic [63:0] pos [3];
        logic [63:0] nrm [3];
        v = '{default: '0};
        ns = stack_count;
        nv = sector_count;
        if (ns == 0 || ns > MAX_DIV || nv == 0 || nv > MAX_DIV || i > ns || j > nv)
        begin
            v.index_error = 1'b1;
            return v;
        end
        ph = ((64'(i) << 31) + ns / 2) / ns;
        phase_trig(ph[31:0], sw, cw);
        ph = ((64'(j) << 32) + nv / 2) / nv;
        phase_trig(ph[31:0], sv, cv);
        rad = longint'(radius_q88);
        p[0] = shift_round_away(sw * cv, 30);
        p[1] = shift_round_away(sw * sv, 30);
        p[2] = cw;
        for (int k = 0; k < 3; k++)
        begin
            pos[k] = shift_round_away(rad * p[k], 30);
            nrm[k] = shift_round_away(p[k], 16);
        end
        v.pos_x = pos[0][16:0];
        v.pos_y = pos[1][16:0];
        v.pos_z = pos[2][16:0];
        v.norm_x = nrm[0][15:0];
        v.norm_y = nrm[1][15:0];
        v.norm_z = nrm[2][15:0];
        ph = ((64'(j) << 16) + nv / 2) / nv;
        v.tex_s = ph[16:0];
        ph = ((64'(i) << 16) + ns / 2) / ns;
        v.tex_t = ph[16:0];
        return v;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_vertex(input logic [8:0] i, input logic [8:0] j);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, j, i};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_vertices = {pending_vertices, predict_vertex(i, j)};
    endtask

    // Drop the input, let the pipeline drain and settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input uvs_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:  radius_q88 = value;
            REG_STACKS:  stack_count = value[8:0];
            REG_SECTORS: sector_count = value[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_sphere(input logic [15:0] r, input logic [15:0] ns,
                              input logic [15:0] nv);
        wait_idle();
        write_reg(REG_RADIUS, r);
        write_reg(REG_STACKS, ns);
        write_reg(REG_SECTORS, nv);
    endtask

    // Index in range most of the time, any 9-bit value otherwise
    function automatic logic [8:0] pick_index(input logic [8:0] count);
        if ($urandom_range(99) < 85 && count != 0 && count <= MAX_DIV)
            return 9'($urandom_range(count));
        return 9'($urandom_range(511));
    endfunction

    task automatic test_reset_defaults();
        send_vertex(9'd0, 9'd0);
        send_vertex(9'd16, 9'd0);
        send_vertex(9'd8, 9'd8);
        send_vertex(9'd16, 9'd32);
        send_vertex(9'd5, 9'd32);
        send_vertex(9'd17, 9'd0);
        send_vertex(9'd0, 9'd33);
        send_vertex(9'd511, 9'd511);
    endtask

    task automatic test_config_extremes();
        set_sphere(16'd0, 16'd8, 16'd8);
        send_vertex(9'd4, 9'd3);
        send_vertex(9'd8, 9'd8);
        set_sphere(16'hFFFF, 16'd1, 16'd1);
        send_vertex(9'd0, 9'd0);
        send_vertex(9'd1, 9'd1);
        send_vertex(9'd0, 9'd1);
        send_vertex(9'd2, 9'd0);
        set_sphere(16'hFFFF, 16'd256, 16'd256);
        send_vertex(9'd128, 9'd0);
        send_vertex(9'd128, 9'd64);
        send_vertex(9'd256, 9'd256);
        send_vertex(9'd257, 9'd256);
        send_vertex(9'd85, 9'd171);
        // Zero or oversized counts reject everything
        set_sphere(16'd256, 16'd0, 16'd16);
        send_vertex(9'd0, 9'd0);
        set_sphere(16'd256, 16'd16, 16'h01FF);
        send_vertex(9'd1, 9'd1);
        set_sphere(16'd256, 16'd257, 16'd16);
        send_vertex(9'd0, 9'd0);
    endtask

    task automatic test_random_spheres();
        logic [15:0] r;
        logic [15:0] ns;
        logic [15:0] nv;
        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(5))
                0:       r = 16'd0;
                1:       r = 16'hFFFF;
                default: r = 16'($urandom_range(65535));
            endcase
            ns = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(256, 1));
            nv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(256, 1));
            if (phase < 2)
            begin
                ns = 16'($urandom_range(4, 1));
                nv = 16'($urandom_range(4, 1));
            end
            set_sphere(r, ns, nv);
            for (int n = 0; n < 200; n++)
                send_vertex(pick_index(stack_count), pick_index(sector_count));
        end
    endtask

    // Stall the output long enough that the input backs up
    task automatic test_output_stall();
        set_sphere(16'd300, 16'd24, 16'd48);
        hold_ask++;
        for (int n = 0; n < 150; n++)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {6'd0, pick_index(sector_count), pick_index(stack_count)};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            pending_vertices = {pending_vertices,
                                predict_vertex(s_tdata[8:0], s_tdata[17:9])};
        end
    endtask

    // Receiver: random ready, with an occasional long hold-off
    initial
    begin
        int hold_seen;
        int r;
        hold_seen = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            r = $urandom_range(99);
            if (r < 60)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(posedge clk);
            end
            else if (r < 95)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(3, 1)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(40, 10)) @(posedge clk);
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        vertex_t w;
        vertex_t g;
        if (rst_n && m_tvalid && m_tready)
        begin
            g.pos_x = m_tdata[16:0];
            g.pos_y = m_tdata[33:17];
            g.pos_z = m_tdata[50:34];
            g.norm_x = m_tdata[66:51];
            g.norm_y = m_tdata[82:67];
            g.norm_z = m_tdata[98:83];
            g.tex_s = m_tdata[115:99];
            g.tex_t = m_tdata[132:116];
            g.index_error = m_tuser[0];
            if (pending_vertices.size() == 0)
            begin
                $display("%0t unexpected result beat %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                w = pending_vertices.pop_front();
                if (g.pos_x !== w.pos_x || g.pos_y !== w.pos_y || g.pos_z !== w.pos_z)
                begin
                    $display("%0t pos expected %h %h %h actual %h %h %h", $time,
                             w.pos_x, w.pos_y, w.pos_z, g.pos_x, g.pos_y, g.pos_z);
                    fail_count++;
                end
                if (g.norm_x !== w.norm_x || g.norm_y !== w.norm_y ||
                    g.norm_z !== w.norm_z)
                begin
                    $display("%0t norm expected %h %h %h actual %h %h %h", $time,
                             w.norm_x, w.norm_y, w.norm_z, g.norm_x, g.norm_y, g.norm_z);
                    fail_count++;
                end
                if (g.tex_s !== w.tex_s || g.tex_t !== w.tex_t)
                begin
                    $display("%0t tex expected %h %h actual %h %h", $time,
                             w.tex_s, w.tex_t, g.tex_s, g.tex_t);
                    fail_count++;
                end
                if (g.index_error !== w.index_error)
                begin
                    $display("%0t index_error expected %b actual %b", $time,
                             w.index_error, g.index_error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        fail_count = 0;
        hold_ask = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        radius_q88 = 16'd256;
        stack_count = 9'd16;
        sector_count = 9'd32;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_output_stall();
        test_random_spheres();
        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
